// ----- rtl/core/dfhe_pkg.sv -----
// ----------------------------------------------------------------------------
// dfhe_pkg
// Shared types, constants and bit-reversal helpers for the fixed-Huffman
// DEFLATE encoder.
// ----------------------------------------------------------------------------
package dfhe_pkg;

   // token kinds
   typedef enum logic [1:0] {
      ACT_SKIP    = 2'd0,
      ACT_LITERAL = 2'd1,
      ACT_MATCH   = 2'd2,
      ACT_IGNORE  = 2'd3
   } action_type;

   // block header: bfinal = 1, btype = 01, first bit in bit 0
   localparam logic [2:0] HDR_BITS = 3'b011;
   localparam int HDR_LEN = 3;
   // end-of-block symbol 256 is seven zero bits
   localparam int EOB_LEN = 7;

   // literal code ranges
   localparam int LIT_SPLIT  = 143;
   localparam int LIT_OFS_LO = 48;
   localparam int LIT_OFS_HI = 256;

   // match length coding
   localparam int MIN_MATCH     = 3;
   localparam int MAX_MATCH     = 16;
   localparam int LEN_SPLIT     = 10;
   localparam int LEN_SYM_OFS   = 2;
   localparam int LEN_PAIR_BASE = 9;
   localparam int LEN_CODE_BITS = 7;
   localparam int DIST_CODE_BITS = 5;

   // longest token code: 8 length bits, 5 distance bits, 13 extra bits
   localparam int CODE_W     = 26;
   localparam int CODE_LEN_W = 5;

   // result word
   localparam int DATA_W = 64;
   localparam int KEEP_W = 8;

   // result queue
   localparam int Q_DEPTH = 3;
   localparam int Q_IDX_W = 2;
   localparam int Q_CNT_W = 2;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  value;
      logic [14:0] distance_minus_one;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] word_data;
      logic [KEEP_W-1:0] byte_keep;
      logic              last_word;
   } rsp_type;

   typedef struct packed {
      logic [CODE_W-1:0]     bits;
      logic [CODE_LEN_W-1:0] len;
   } code_type;

   // up to two results written into the queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic [4:0] rev5(input logic [4:0] v);
      logic [4:0] r;
      for (int i = 0; i < 5; i++) r[i] = v[4-i];
      return r;
   endfunction

   function automatic logic [6:0] rev7(input logic [6:0] v);
      logic [6:0] r;
      for (int i = 0; i < 7; i++) r[i] = v[6-i];
      return r;
   endfunction

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[i] = v[7-i];
      return r;
   endfunction

   function automatic logic [8:0] rev9(input logic [8:0] v);
      logic [8:0] r;
      for (int i = 0; i < 9; i++) r[i] = v[8-i];
      return r;
   endfunction

endpackage

// ----- rtl/core/dfhe_if.sv -----
// ----------------------------------------------------------------------------
// dfhe_if
// Valid/ready channels for tokens in and packed words out.
// ----------------------------------------------------------------------------
interface dfhe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  value;
   logic [14:0] distance_minus_one;
   logic        last_in;

   modport source (output valid, action, value, distance_minus_one, last_in,
                   input ready);
   modport sink   (input valid, action, value, distance_minus_one, last_in,
                   output ready);
endinterface

interface dfhe_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] word_data;
   logic [7:0]  byte_keep;
   logic        last_word;

   modport source (output valid, word_data, byte_keep, last_word, input ready);
   modport sink   (input valid, word_data, byte_keep, last_word, output ready);
endinterface

// ----- rtl/core/dfhe_token_coder.sv -----
// ----------------------------------------------------------------------------
// dfhe_token_coder
// Maps one token to its fixed-Huffman bit string, first bit in bit 0,
// together with its length in bits.
// ----------------------------------------------------------------------------
module dfhe_token_coder import dfhe_pkg::*; (
   input  req_type  tok,
   output code_type code
);

   logic [7:0]  mlen;
   logic [7:0]  lsub;
   logic [7:0]  lcode;
   logic [3:0]  lbits;
   logic [3:0]  top;
   logic [3:0]  ebits;
   logic [4:0]  dsym;
   logic [12:0] extra;
   logic [14:0] dist_m1;
   logic [8:0]  lit_sum;

   always_comb begin
      code    = '0;
      dist_m1 = tok.distance_minus_one;
      lit_sum = '0;
      lsub    = '0;
      lcode   = '0;
      lbits   = '0;
      top     = '0;
      ebits   = '0;
      dsym    = '0;
      extra   = '0;

      // clamp match length
      if (tok.value < 8'(MIN_MATCH))      mlen = 8'(MIN_MATCH);
      else if (tok.value > 8'(MAX_MATCH)) mlen = 8'(MAX_MATCH);
      else                                mlen = tok.value;

      case (action_type'(tok.action))
         ACT_LITERAL: begin
            if (tok.value <= 8'(LIT_SPLIT)) begin
               lit_sum   = 9'(tok.value) + 9'(LIT_OFS_LO);
               code.bits = CODE_W'(rev8(lit_sum[7:0]));
               code.len  = CODE_LEN_W'(8);
            end else begin
               lit_sum   = 9'(tok.value) + 9'(LIT_OFS_HI);
               code.bits = CODE_W'(rev9(lit_sum));
               code.len  = CODE_LEN_W'(9);
            end
         end
         ACT_MATCH: begin
            // length symbol, with one extra bit above the short range
            if (mlen <= 8'(LEN_SPLIT)) begin
               lcode = {1'b0, rev7(7'(mlen - 8'(LEN_SYM_OFS)))};
               lbits = 4'(LEN_CODE_BITS);
            end else begin
               lsub  = mlen - 8'(LEN_SPLIT + 1);
               lcode = {lsub[0], rev7(7'(8'(LEN_PAIR_BASE) + (lsub >> 1)))};
               lbits = 4'(LEN_CODE_BITS + 1);
            end

            // distance symbol from the leading one
            if (dist_m1 < 15'd4) begin
               dsym = 5'(dist_m1);
            end else begin
               for (int i = 1; i < 15; i++) begin
                  if (dist_m1[i]) top = 4'(i);
               end
               ebits = top - 4'd1;
               dsym  = {top, 1'b0} + 5'(dist_m1[ebits]);
               extra = 13'(dist_m1 & ~(15'h7FFF << ebits));
            end

            code.bits = CODE_W'(lcode)
                      | (CODE_W'(rev5(dsym)) << lbits)
                      | (CODE_W'(extra) << (lbits + 4'(DIST_CODE_BITS)));
            code.len  = CODE_LEN_W'(lbits) + CODE_LEN_W'(DIST_CODE_BITS)
                      + CODE_LEN_W'(ebits);
         end
         default: begin
            code = '0;
         end
      endcase
   end

endmodule

// ----- rtl/core/dfhe_out_queue.sv -----
// ----------------------------------------------------------------------------
// dfhe_out_queue
// Three-entry result queue; takes up to two words a cycle, hands out one while rsp_ch.ready is high.
// ----------------------------------------------------------------------------
module dfhe_out_queue import dfhe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  push_type           push,
   output logic [Q_CNT_W-1:0] level,
   dfhe_rsp_if.source         rsp_ch
);

   rsp_type             ent_ff [Q_DEPTH];
   rsp_type             ent_in [Q_DEPTH];
   logic [Q_IDX_W-1:0]  head_ff, head_in;
   logic [Q_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [Q_IDX_W-1:0]  tail, tail2;
   logic                pop;

   function automatic logic [Q_IDX_W-1:0] wrap(input logic [Q_IDX_W:0] s);
      return (s >= (Q_IDX_W+1)'(Q_DEPTH)) ? Q_IDX_W'(s - (Q_IDX_W+1)'(Q_DEPTH))
                                          : Q_IDX_W'(s);
   endfunction

   // head of queue drives the channel
   assign rsp_ch.valid     = (cnt_ff != '0);
   assign rsp_ch.word_data = ent_ff[head_ff].word_data;
   assign rsp_ch.byte_keep = ent_ff[head_ff].byte_keep;
   assign rsp_ch.last_word = ent_ff[head_ff].last_word;
   assign level            = cnt_ff;

   assign pop   = rsp_ch.valid && rsp_ch.ready;
   assign tail  = wrap((Q_IDX_W+1)'(head_ff) + (Q_IDX_W+1)'(cnt_ff));
   assign tail2 = wrap((Q_IDX_W+1)'(tail) + (Q_IDX_W+1)'(1));

   // entry writes
   always_comb begin
      for (int i = 0; i < Q_DEPTH; i++) ent_in[i] = ent_ff[i];
      if (push.count != 2'd0) ent_in[tail]  = push.first;
      if (push.count == 2'd2) ent_in[tail2] = push.second;
   end

   // pointers and fill level
   always_comb begin
      head_in = pop ? wrap((Q_IDX_W+1)'(head_ff) + (Q_IDX_W+1)'(1)) : head_ff;
      cnt_in  = cnt_ff + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Q_DEPTH; i++) ent_ff[i] <= ent_in[i];
   end

endmodule

// ----- rtl/core/deflate_fixed_huffman_encoder.sv -----
// ----------------------------------------------------------------------------
// deflate_fixed_huffman_encoder
// Single-block DEFLATE encoder with fixed Huffman codes: packs token codes
// behind the block header and emits OUT_WORD_BITS-wide words.
// ----------------------------------------------------------------------------
// a token's words reach rsp through the token register and then the result queue
// throughput: one token per cycle while the result queue holds at most one
//   word; a last token that closes two words leaves two words in the
//   three-entry result queue, so the next token waits until one is handed out
// reset: synchronous; bit buffer back to header 011 with three bits pending,
//   token register and result queue emptied; no clearing pass
module deflate_fixed_huffman_encoder import dfhe_pkg::*; #(
   parameter int OUT_WORD_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   dfhe_req_if.sink    req_ch,
   dfhe_rsp_if.source  rsp_ch
);

   localparam int BUF_W      = OUT_WORD_BITS + CODE_W + EOB_LEN;
   localparam int CNT_W      = $clog2(BUF_W + 1);
   localparam int KEEP_BYTES = (OUT_WORD_BITS + 7) / 8;
   localparam logic [KEEP_W-1:0] KEEP_FULL = KEEP_W'((1 << KEEP_BYTES) - 1);

   req_type              tok_ff, tok_in;
   logic                 tok_vld_ff, tok_vld_in;
   logic [BUF_W-1:0]     buf_ff, buf_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   code_type             code;
   push_type             push;
   logic [Q_CNT_W-1:0]   q_level;
   logic                 fire;
   logic                 accept;
   logic [BUF_W-1:0]     appended;
   logic [BUF_W-1:0]     shifted;
   logic [CNT_W-1:0]     sum;
   logic [CNT_W-1:0]     total;
   logic [BUF_W-1:0]     fin_src;
   logic [CNT_W-1:0]     fin_cnt;
   logic [CNT_W-1:0]     fin_bytes;

   // token register
   assign fire          = tok_vld_ff && (q_level <= Q_CNT_W'(Q_DEPTH - 2));
   assign req_ch.ready  = !tok_vld_ff || fire;
   assign accept        = req_ch.valid && req_ch.ready;

   always_comb begin
      tok_in     = tok_ff;
      tok_vld_in = tok_vld_ff;
      if (accept) begin
         tok_in.action             = req_ch.action;
         tok_in.value              = req_ch.value;
         tok_in.distance_minus_one = req_ch.distance_minus_one;
         tok_in.last_in            = req_ch.last_in;
         tok_vld_in                = 1'b1;
      end else if (fire) begin
         tok_vld_in = 1'b0;
      end
   end

   // code lookup
   dfhe_token_coder u_coder (
      .tok  (tok_ff),
      .code (code)
   );

   // append to bit buffer and cut off words
   assign appended = buf_ff | (BUF_W'(code.bits) << cnt_ff);
   assign shifted  = appended >> OUT_WORD_BITS;
   assign sum      = cnt_ff + CNT_W'(code.len);
   assign total    = sum + CNT_W'(EOB_LEN);

   always_comb begin
      buf_in    = buf_ff;
      cnt_in    = cnt_ff;
      push      = '0;
      fin_src   = appended;
      fin_cnt   = total;

      // a full word, used whenever one goes out first
      push.first.word_data = DATA_W'(appended[OUT_WORD_BITS-1:0]);
      push.first.byte_keep = KEEP_FULL;
      push.first.last_word = 1'b0;

      // the closing word when the token is the last
      if (total > CNT_W'(OUT_WORD_BITS)) begin
         fin_src = shifted;
         fin_cnt = total - CNT_W'(OUT_WORD_BITS);
      end
      fin_bytes = (fin_cnt + CNT_W'(7)) >> 3;
      push.second.word_data = DATA_W'(fin_src[OUT_WORD_BITS-1:0]);
      push.second.byte_keep = KEEP_W'((9'd1 << fin_bytes) - 9'd1);
      push.second.last_word = 1'b1;

      if (fire) begin
         if (!tok_ff.last_in) begin
            if (sum >= CNT_W'(OUT_WORD_BITS)) begin
               push.count = 2'd1;
               buf_in     = shifted;
               cnt_in     = sum - CNT_W'(OUT_WORD_BITS);
            end else begin
               buf_in = appended;
               cnt_in = sum;
            end
         end else begin
            if (total > CNT_W'(OUT_WORD_BITS)) begin
               push.count = 2'd2;
            end else begin
               push.count = 2'd1;
               push.first = push.second;
            end
            buf_in = BUF_W'(HDR_BITS);
            cnt_in = CNT_W'(HDR_LEN);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_vld_ff <= 1'b0;
         buf_ff     <= BUF_W'(HDR_BITS);
         cnt_ff     <= CNT_W'(HDR_LEN);
      end else begin
         tok_vld_ff <= tok_vld_in;
         buf_ff     <= buf_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   // result queue
   dfhe_out_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .level  (q_level),
      .rsp_ch (rsp_ch)
   );

   // checks
   a_cnt_below_word: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_W'(OUT_WORD_BITS))
      else $error("pending bit count reached a full word");

   a_clean_above: assert property (@(posedge clock) disable iff (reset)
      (buf_ff >> cnt_ff) == '0)
      else $error("stray bits above the pending count");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      fire && tok_ff.last_in |=> cnt_ff == CNT_W'(HDR_LEN))
      else $error("stream did not restart after its last token");

   a_last_keep: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.last_word |-> rsp_ch.byte_keep[0])
      else $error("final word has no valid byte");

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-Huffman DEFLATE encoder. Tokens are sent
// over the request channel with random gaps. Each accepted token runs through
// a bit-packing predictor that queues the words the block should emit. Every
// word on the result channel, taken under random back-pressure, is compared
// field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dfhe_pkg::*;

   localparam int WORD_BITS     = 64;
   localparam int RANDOM_TOKENS = 1800;
   localparam int DRAIN_CYCLES  = 24;
   // watchdog bound for 1800 random tokens plus the directed ones and stalled words
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [63:0] WORD_MASK =
      (WORD_BITS >= 64) ? {64{1'b1}} : ((64'd1 << WORD_BITS) - 64'd1);

   logic clock;
   logic reset;

   dfhe_req_if req_bus ();
   dfhe_rsp_if rsp_bus ();

   deflate_fixed_huffman_encoder #(
      .OUT_WORD_BITS (WORD_BITS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // predicted bit stream and the words still owed by the block
   logic [127:0] stream_bits;
   int unsigned  stream_fill;
   rsp_type      expected_words[$];

   int error_count;
   int send_gap_max;
   int stall_max;
   int cycle_count;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [31:0] reverse_bits(input logic [31:0] v, input int n);
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < n; i++) r[n-1-i] = v[i];
      return r;
   endfunction

   // huffman code of one token, first bit in bit 0; returns the bit count
   function automatic int token_code(input action_type act, input logic [7:0] val,
                                     input logic [14:0] dist_m1,
                                     output logic [25:0] code);
      int          run;
      int          lbits;
      int          ebits;
      int          msb;
      logic [4:0]  dsym;
      logic [14:0] extra;
      code = '0;
      case (act)
         ACT_LITERAL: begin
            // 0..143 take eight bits from 0x30, 144..255 nine bits from 0x190
            if (val <= 143) begin
               code = 26'(reverse_bits(int'(val) + 48, 8));
               return 8;
            end
            code = 26'(reverse_bits(int'(val) + 256, 9));
            return 9;
         end
         ACT_MATCH: begin
            // length clamped to 3..16
            run = (val < 3) ? 3 : (val > 16) ? 16 : int'(val);
            if (run <= 10) begin
               code  = 26'(reverse_bits(run - 2, 7));
               lbits = 7;
            end else begin
               // symbols 265..267 cover length pairs with one extra bit
               code    = 26'(reverse_bits(9 + (run - 11) / 2, 7));
               code[7] = ((run - 11) % 2) != 0;
               lbits   = 8;
            end
            if (dist_m1 < 4) begin
               dsym  = dist_m1[4:0];
               ebits = 0;
               extra = '0;
            end else begin
               msb = 0;
               for (int b = 0; b < 15; b++) if (dist_m1[b]) msb = b;
               ebits = msb - 1;
               dsym  = 5'(2 * msb + int'(dist_m1[ebits]));
               extra = dist_m1 & 15'((1 << ebits) - 1);
            end
            code = code | (26'(reverse_bits(dsym, 5)) << lbits);
            code = code | (26'(extra) << (lbits + 5));
            return lbits + 5 + ebits;
         end
         default: return 0;
      endcase
   endfunction

   function automatic logic [7:0] keep_mask(input int bits);
      int bytes;
      bytes = (bits + 7) / 8;
      if (bytes > 8) bytes = 8;
      return 8'((1 << bytes) - 1);
   endfunction

   // fresh stream: block header bfinal = 1, btype = 01
   task automatic restart_stream();
      stream_bits = 128'b011;
      stream_fill = 3;
   endtask

   task automatic emit_full_word();
      rsp_type w;
      w.word_data = stream_bits[63:0] & WORD_MASK;
      w.byte_keep = keep_mask(WORD_BITS);
      w.last_word = 1'b0;
      expected_words.push_back(w);
      stream_bits = stream_bits >> WORD_BITS;
      stream_fill -= WORD_BITS;
   endtask

   // append one token and queue the words it completes
   task automatic pack_token(input req_type tok);
      logic [25:0] code;
      int          n;
      rsp_type     w;
      n = token_code(action_type'(tok.action), tok.value, tok.distance_minus_one, code);
      stream_bits = stream_bits | (128'(code) << stream_fill);
      stream_fill += n;
      if (!tok.last_in) begin
         if (stream_fill >= WORD_BITS) emit_full_word();
      end else begin
         // end-of-block is seven zero bits, then flush
         stream_fill += 7;
         if (stream_fill > WORD_BITS) emit_full_word();
         w.word_data = stream_bits[63:0] & WORD_MASK;
         w.byte_keep = keep_mask(stream_fill);
         w.last_word = 1'b1;
         expected_words.push_back(w);
         restart_stream();
      end
   endtask

   // one token transfer after a random gap
   task automatic send_token(input action_type act, input int val, input int dist_m1,
                             input bit last);
      int      gap;
      req_type tok;
      tok.action             = act;
      tok.value              = val[7:0];
      tok.distance_minus_one = dist_m1[14:0];
      tok.last_in            = last;
      gap = $urandom_range(send_gap_max, 0);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid              = 1'b1;
      req_bus.action             = tok.action;
      req_bus.value              = tok.value;
      req_bus.distance_minus_one = tok.distance_minus_one;
      req_bus.last_in            = tok.last_in;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pack_token(tok);
   endtask

   // result side: random stall before each word, then compare
   task automatic check_words();
      int      stall;
      rsp_type want;
      forever begin
         stall = $urandom_range(stall_max, 0);
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h keep %h last %b",
                            rsp_bus.word_data, rsp_bus.byte_keep, rsp_bus.last_word));
         end else begin
            want = expected_words.pop_front();
            if (rsp_bus.word_data !== want.word_data)
               report_mismatch($sformatf("word_data %h, want %h",
                               rsp_bus.word_data, want.word_data));
            if (rsp_bus.byte_keep !== want.byte_keep)
               report_mismatch($sformatf("byte_keep %h, want %h",
                               rsp_bus.byte_keep, want.byte_keep));
            if (rsp_bus.last_word !== want.last_word)
               report_mismatch($sformatf("last_word %b, want %b",
                               rsp_bus.last_word, want.last_word));
         end
      end
   endtask

   // literal code edges; stream ends on exactly one full final word
   task automatic test_literal_codes();
      send_token(ACT_LITERAL, 0, 0, 1'b0);
      send_token(ACT_LITERAL, 143, 0, 1'b0);
      send_token(ACT_LITERAL, 144, 0, 1'b0);
      send_token(ACT_LITERAL, 255, 0, 1'b0);
      send_token(ACT_MATCH, 3, 0, 1'b0);
      send_token(ACT_LITERAL, 0, 0, 1'b0);
      send_token(ACT_SKIP, 0, 0, 1'b1);
   endtask

   // length codes, both clamps, short and extra-bit distances
   task automatic test_match_lengths();
      send_token(ACT_MATCH, 0, 0, 1'b0);
      send_token(ACT_MATCH, 10, 3, 1'b0);
      send_token(ACT_MATCH, 11, 4, 1'b0);
      send_token(ACT_MATCH, 12, 5, 1'b0);
      send_token(ACT_MATCH, 200, 6, 1'b0);
      send_token(ACT_MATCH, 16, 255, 1'b1);
   endtask

   // ignored and skipped tokens add no bits; last still closes the stream
   task automatic test_ignored_tokens();
      send_token(ACT_IGNORE, 255, 32767, 1'b1);
      send_token(ACT_SKIP, 77, 100, 1'b0);
      send_token(ACT_IGNORE, 12, 9, 1'b0);
      send_token(ACT_LITERAL, 65, 0, 1'b1);
   endtask

   // last token overflows the word: full word then final word
   task automatic test_two_word_flush();
      repeat (5) send_token(ACT_LITERAL, 255, 0, 1'b0);
      send_token(ACT_MATCH, 16, 32767, 1'b1);
   endtask

   // random streams of mostly literals and matches
   task automatic test_random_streams();
      int         sent;
      int         run_len;
      int         pick;
      int         val;
      int         dist_m1;
      int         width;
      bit         last;
      action_type act;
      sent = 0;
      while (sent < RANDOM_TOKENS) begin
         // some streams run without gaps or stalls on one or both sides
         pick = $urandom_range(3, 0);
         send_gap_max = (pick == 0 || pick == 2) ? 0 : 9;
         stall_max    = (pick <= 1) ? 0 : 9;
         run_len = $urandom_range(60, 1);
         for (int i = 0; i < run_len; i++) begin
            pick = $urandom_range(99, 0);
            if (pick < 50)      act = ACT_LITERAL;
            else if (pick < 88) act = ACT_MATCH;
            else if (pick < 94) act = ACT_SKIP;
            else                act = ACT_IGNORE;
            val = $urandom_range(255, 0);
            if (act == ACT_MATCH && $urandom_range(3, 0) != 0) val = $urandom_range(16, 3);
            width   = $urandom_range(15, 0);
            dist_m1 = $urandom & ((1 << width) - 1);
            last    = (i == run_len - 1) || ($urandom_range(199, 0) == 0);
            send_token(act, val, dist_m1, last);
            sent++;
            if (last) break;
         end
      end
      send_gap_max = 9;
      stall_max    = 9;
   endtask

   // test sequence
   initial begin
      reset                      = 1'b1;
      req_bus.valid              = 1'b0;
      req_bus.action             = '0;
      req_bus.value              = '0;
      req_bus.distance_minus_one = '0;
      req_bus.last_in            = 1'b0;
      rsp_bus.ready              = 1'b0;
      error_count                = 0;
      send_gap_max               = 9;
      stall_max                  = 9;
      restart_stream();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      fork
         check_words();
      join_none

      test_literal_codes();
      test_match_lengths();
      test_ignored_tokens();
      test_two_word_flush();
      test_random_streams();

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
